// ===== hdl/rbb_pkg.sv =====
// Package: shared constants, codes and state type of the RGB box blur.
package rbb_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 11;
    localparam int RADIUS_W   = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_COUNT,
        ST_SUB_RD,
        ST_SUB,
        ST_COL,
        ST_MOD,
        ST_RD,
        ST_ACC,
        ST_COLDONE,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

// ===== hdl/rbb_if.sv =====
// Interfaces: pixel input channel and result output channel.
interface rbb_pix_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output opcode, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input opcode, input red, input green, input blue,
                    output ready);
endinterface

interface rbb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

// ===== hdl/rgb_box_blur_clipped.sv =====
// Top level of the streaming RGB box blur with a clipped border.
//
// Pixels enter in raster order; each result is the floor mean of the clipped
// (2R+1) square window around a pixel and leaves R*W+R pixel positions later,
// with drain items releasing the tail of the frame. A pixel item that writes
// the line store and causes no result is popped in the idle state and keeps
// the back end idle. A result passes through setup, count, an optional column
// subtract, per loaded column a row address reduction and a line store read
// per window row, the bit-serial divider and the result register; the first
// pixel of each row loads up to R+1 columns, every other pixel at most one.
// The line store's single read port, walked a window row at a time, and the
// bit-serial divider bound the result rate; the front part keeps taking
// items while the back part works, until the two-entry command queue fills.
module rgb_box_blur_clipped #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rbb_pix_if.sink                        i_pix,
    rbb_res_if.source                      o_res
);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic [WW-1:0] w;
        logic [HW-1:0] h;
        logic [RW-1:0] r;
    } t_geom;

    typedef struct packed {
        logic                      wr;
        logic [AW-1:0]             addr;
        logic [rbb_pkg::PIX_W-1:0] pix;
        logic                      emit;
        logic [WW-1:0]             ox;
        logic [HW-1:0]             oy;
        logic                      last;
    } t_cmd;

    logic [rbb_pkg::WIDTH_W-1:0]  r_cfg_w;
    logic [rbb_pkg::HEIGHT_W-1:0] r_cfg_h;
    logic [rbb_pkg::RADIUS_W-1:0] r_cfg_r;
    logic   restart, push, pop, full, empty;
    t_geom  geom;
    t_cmd   cmd_in, cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= rbb_pkg::WIDTH_RST;
            r_cfg_h <= rbb_pkg::HEIGHT_RST;
            r_cfg_r <= rbb_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbb_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[rbb_pkg::WIDTH_W-1:0];
                rbb_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[rbb_pkg::HEIGHT_W-1:0];
                rbb_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[rbb_pkg::RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == rbb_pkg::CFG_WIDTH ||
                                  i_cfg_idx == rbb_pkg::CFG_HEIGHT ||
                                  i_cfg_idx == rbb_pkg::CFG_RADIUS);

    always_comb begin
        if (r_cfg_w == '0) begin
            geom.w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            geom.w = WW'(MAX_WIDTH);
        end else begin
            geom.w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            geom.h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            geom.h = HW'(MAX_HEIGHT);
        end else begin
            geom.h = HW'(r_cfg_h);
        end
        if (32'(r_cfg_r) > MAX_RADIUS) begin
            geom.r = RW'(MAX_RADIUS);
        end else begin
            geom.r = RW'(r_cfg_r);
        end
    end

    rbb_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS),
        .t_cmd(t_cmd), .t_geom(t_geom)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_pix     (i_pix),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (cmd_in)
    );

    rbb_fifo #(.t_cmd(t_cmd)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    rbb_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS),
        .t_cmd(t_cmd), .t_geom(t_geom)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_empty (empty),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

// ===== hdl/rbb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rbb_fifo.sv =====
// Two-entry command queue between the front and the back.
module rbb_fifo #(
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

// ===== hdl/rbb_front.sv =====
// Front: accepts items, tracks frame positions and issues write/emit commands.
module rbb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 63,
    parameter type t_cmd  = logic,
    parameter type t_geom = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_geom i_geom,
    input  logic i_restart,
    rbb_pix_if.sink i_pix,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);

    logic [PW-1:0] r_in_pos, n_in_pos, r_out_pos, n_out_pos;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [WW-1:0] r_ox, n_ox;
    logic [HW-1:0] r_oy, n_oy;
    logic [PW-1:0] total, lag;
    logic          acc, is_pix, in_done, out_open, wr, emit, last;

    assign total    = PW'(i_geom.w) * PW'(i_geom.h);
    assign lag      = PW'(i_geom.r) * PW'(i_geom.w) + PW'(i_geom.r);
    assign i_pix.ready = ~i_full;
    assign acc      = i_pix.valid & i_pix.ready;
    assign is_pix   = (i_pix.opcode == rbb_pkg::OP_PIXEL);
    assign in_done  = (r_in_pos >= total);
    assign out_open = (r_out_pos < total);
    assign wr       = acc & is_pix & ~in_done;
    assign emit     = acc & (is_pix ? (~in_done & (r_in_pos >= lag) & out_open)
                                    : (in_done & out_open));
    assign last     = ((r_out_pos + PW'(1)) >= total);

    always_comb begin
        n_in_pos  = r_in_pos;
        n_out_pos = r_out_pos;
        n_wr_ptr  = r_wr_ptr;
        n_ox      = r_ox;
        n_oy      = r_oy;
        if (i_restart || (emit && last)) begin
            n_in_pos  = '0;
            n_out_pos = '0;
            n_wr_ptr  = '0;
            n_ox      = '0;
            n_oy      = '0;
        end else begin
            if (wr) begin
                n_in_pos = r_in_pos + PW'(1);
                n_wr_ptr = (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + AW'(1);
            end
            if (emit) begin
                n_out_pos = r_out_pos + PW'(1);
                if (r_ox == i_geom.w - WW'(1)) begin
                    n_ox = '0;
                    n_oy = r_oy + HW'(1);
                end else begin
                    n_ox = r_ox + WW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_wr_ptr  <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
        end else begin
            r_in_pos  <= n_in_pos;
            r_out_pos <= n_out_pos;
            r_wr_ptr  <= n_wr_ptr;
            r_ox      <= n_ox;
            r_oy      <= n_oy;
        end
    end

    always_comb begin
        o_cmd.wr   = wr;
        o_cmd.addr = r_wr_ptr;
        o_cmd.pix  = {i_pix.red, i_pix.green, i_pix.blue};
        o_cmd.emit = emit;
        o_cmd.ox   = r_ox;
        o_cmd.oy   = r_oy;
        o_cmd.last = last;
    end

    assign o_push = wr | emit;
endmodule

// ===== hdl/rbb_back.sv =====
// Back: line store writes, column and window sums, division and result register.
module rbb_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 63,
    parameter type t_cmd  = logic,
    parameter type t_geom = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_geom i_geom,
    input  logic i_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    rbb_res_if.source o_res
);
    localparam int CH    = rbb_pkg::CH_W;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int EW    = ((WW > HW) ? ((WW > RW) ? WW : RW) : ((HW > RW) ? HW : RW)) + 1;
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RAW0  = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_WIDTH + 1);
    localparam int RAWW  = (RAW0 > AW + 1) ? RAW0 : AW + 1;
    localparam int CAW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CSW   = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int SW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int CW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int BCW   = $clog2(SW);
    localparam int PRW   = HW + WW;

    rbb_pkg::t_back_state r_state, n_state;

    t_cmd            r_cmd, n_cmd;
    logic [HW-1:0]   r_lo, n_lo, r_hi, n_hi, r_y, n_y;
    logic [WW-1:0]   r_left, n_left, r_right, n_right;
    logic [WW-1:0]   r_c, n_c, r_c_last, n_c_last, r_c_sub, n_c_sub;
    logic            r_load, n_load, r_sub, n_sub;
    logic [CW-1:0]   r_count, n_count;
    logic [RAWW-1:0] r_raw, n_raw;
    logic [CSW-1:0]  r_col [3];
    logic [CSW-1:0]  n_col [3];
    logic [SW-1:0]   r_sum [3];
    logic [SW-1:0]   n_sum [3];
    logic [SW-1:0]   r_num [3];
    logic [SW-1:0]   n_num [3];
    logic [CW-1:0]   r_rem [3];
    logic [CW-1:0]   n_rem [3];
    logic [BCW-1:0]  r_bit, n_bit;
    logic            r_out_valid, n_out_valid;
    logic [CH-1:0]   r_out_ch [3];
    logic [CH-1:0]   n_out_ch [3];
    logic            r_out_last, n_out_last;

    logic                  line_we, col_we, out_free;
    logic [AW-1:0]         line_raddr;
    logic [rbb_pkg::PIX_W-1:0] line_rdata;
    logic [CAW-1:0]        col_waddr, col_raddr;
    logic [3*CSW-1:0]      col_rdata;

    logic [EW-1:0]   ox_e, oy_e, r_e, w_e, h_e;
    logic [EW-1:0]   lo_e, hi_e, left_e, right_e;
    logic [RAWW-1:0] raw_step;
    logic [HW-1:0]   rows;
    logic [WW-1:0]   cols;
    logic [CW:0]     trial [3];

    rbb_ram #(.WIDTH(rbb_pkg::PIX_W), .DEPTH(DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.pix),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    rbb_ram #(.WIDTH(3 * CSW), .DEPTH(MAX_WIDTH)) u_cols (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata ({r_col[0], r_col[1], r_col[2]}),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    assign ox_e    = EW'(r_cmd.ox);
    assign oy_e    = EW'(r_cmd.oy);
    assign r_e     = EW'(i_geom.r);
    assign w_e     = EW'(i_geom.w);
    assign h_e     = EW'(i_geom.h);
    assign lo_e    = (oy_e > r_e) ? oy_e - r_e : '0;
    assign hi_e    = (oy_e + r_e < h_e) ? oy_e + r_e : h_e - EW'(1);
    assign left_e  = (ox_e > r_e) ? ox_e - r_e : '0;
    assign right_e = (ox_e + r_e < w_e) ? ox_e + r_e : w_e - EW'(1);
    assign rows    = r_hi - r_lo + HW'(1);
    assign cols    = r_right - r_left + WW'(1);
    assign out_free = ~r_out_valid | o_res.ready;

    always_comb begin
        raw_step = r_raw + RAWW'(i_geom.w);
        if (raw_step >= RAWW'(DEPTH)) begin
            raw_step = raw_step - RAWW'(DEPTH);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbb_pkg::ST_IDLE: begin
                if (!i_empty && i_cmd.emit) begin
                    n_state = rbb_pkg::ST_SETUP;
                end
            end
            rbb_pkg::ST_SETUP:  n_state = rbb_pkg::ST_COUNT;
            rbb_pkg::ST_COUNT: begin
                if (r_sub) begin
                    n_state = rbb_pkg::ST_SUB_RD;
                end else if (r_load) begin
                    n_state = rbb_pkg::ST_COL;
                end else begin
                    n_state = rbb_pkg::ST_DIV_INIT;
                end
            end
            rbb_pkg::ST_SUB_RD: n_state = rbb_pkg::ST_SUB;
            rbb_pkg::ST_SUB: begin
                n_state = r_load ? rbb_pkg::ST_COL : rbb_pkg::ST_DIV_INIT;
            end
            rbb_pkg::ST_COL:    n_state = rbb_pkg::ST_MOD;
            rbb_pkg::ST_MOD: begin
                if (r_raw < RAWW'(DEPTH)) begin
                    n_state = rbb_pkg::ST_RD;
                end
            end
            rbb_pkg::ST_RD:     n_state = rbb_pkg::ST_ACC;
            rbb_pkg::ST_ACC: begin
                n_state = (r_y == r_hi) ? rbb_pkg::ST_COLDONE : rbb_pkg::ST_RD;
            end
            rbb_pkg::ST_COLDONE: begin
                n_state = (r_c == r_c_last) ? rbb_pkg::ST_DIV_INIT : rbb_pkg::ST_COL;
            end
            rbb_pkg::ST_DIV_INIT: n_state = rbb_pkg::ST_DIV;
            rbb_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = rbb_pkg::ST_OUT;
                end
            end
            rbb_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = rbb_pkg::ST_IDLE;
                end
            end
            default: n_state = rbb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop      = (r_state == rbb_pkg::ST_IDLE) & ~i_empty;
        line_we    = o_pop & i_cmd.wr;
        line_raddr = r_raw[AW-1:0];
        col_we     = (r_state == rbb_pkg::ST_COLDONE);
        col_waddr  = r_c[CAW-1:0];
        col_raddr  = r_c_sub[CAW-1:0];
    end

    // datapath
    always_comb begin
        n_cmd       = r_cmd;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_y         = r_y;
        n_left      = r_left;
        n_right     = r_right;
        n_c         = r_c;
        n_c_last    = r_c_last;
        n_c_sub     = r_c_sub;
        n_load      = r_load;
        n_sub       = r_sub;
        n_count     = r_count;
        n_raw       = r_raw;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        for (int i = 0; i < 3; i++) begin
            n_col[i]    = r_col[i];
            n_sum[i]    = r_sum[i];
            n_num[i]    = r_num[i];
            n_rem[i]    = r_rem[i];
            n_out_ch[i] = r_out_ch[i];
            trial[i]    = {r_rem[i], r_num[i][SW-1]};
        end
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            rbb_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_cmd = i_cmd;
                end
            end
            rbb_pkg::ST_SETUP: begin
                n_lo    = HW'(lo_e);
                n_hi    = HW'(hi_e);
                n_left  = WW'(left_e);
                n_right = WW'(right_e);
                n_c_sub = WW'(ox_e - r_e - EW'(1));
                n_sub   = (r_cmd.ox != '0) && (ox_e > r_e);
                if (r_cmd.ox == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_sum[i] = '0;
                    end
                    n_c      = '0;
                    n_c_last = WW'(right_e);
                    n_load   = 1'b1;
                end else begin
                    n_c      = WW'(ox_e + r_e);
                    n_c_last = WW'(ox_e + r_e);
                    n_load   = (ox_e + r_e < w_e);
                end
            end
            rbb_pkg::ST_COUNT: begin
                n_count = CW'(PRW'(rows) * PRW'(cols));
            end
            rbb_pkg::ST_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_sum[i] = r_sum[i] - SW'(col_rdata[(2-i)*CSW +: CSW]);
                end
            end
            rbb_pkg::ST_COL: begin
                n_raw = RAWW'(PRW'(r_lo) * PRW'(i_geom.w)) + RAWW'(r_c);
                n_y   = r_lo;
                for (int i = 0; i < 3; i++) begin
                    n_col[i] = '0;
                end
            end
            rbb_pkg::ST_MOD: begin
                if (r_raw >= RAWW'(DEPTH)) begin
                    n_raw = r_raw - RAWW'(DEPTH);
                end
            end
            rbb_pkg::ST_ACC: begin
                for (int i = 0; i < 3; i++) begin
                    n_col[i] = r_col[i] + CSW'(line_rdata[(2-i)*CH +: CH]);
                end
                n_raw = raw_step;
                n_y   = r_y + HW'(1);
            end
            rbb_pkg::ST_COLDONE: begin
                for (int i = 0; i < 3; i++) begin
                    n_sum[i] = r_sum[i] + SW'(r_col[i]);
                end
                n_c = r_c + WW'(1);
            end
            rbb_pkg::ST_DIV_INIT: begin
                for (int i = 0; i < 3; i++) begin
                    n_num[i] = r_sum[i];
                    n_rem[i] = '0;
                end
                n_bit = BCW'(SW - 1);
            end
            rbb_pkg::ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (trial[i] >= {1'b0, r_count}) begin
                        n_rem[i] = CW'(trial[i] - {1'b0, r_count});
                        n_num[i] = {r_num[i][SW-2:0], 1'b1};
                    end else begin
                        n_rem[i] = CW'(trial[i]);
                        n_num[i] = {r_num[i][SW-2:0], 1'b0};
                    end
                end
                n_bit = r_bit - BCW'(1);
            end
            rbb_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = r_cmd.last;
                    for (int i = 0; i < 3; i++) begin
                        n_out_ch[i] = r_num[i][CH-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_y        <= n_y;
        r_left     <= n_left;
        r_right    <= n_right;
        r_c        <= n_c;
        r_c_last   <= n_c_last;
        r_c_sub    <= n_c_sub;
        r_load     <= n_load;
        r_sub      <= n_sub;
        r_count    <= n_count;
        r_raw      <= n_raw;
        r_bit      <= n_bit;
        r_out_last <= n_out_last;
        r_col      <= n_col;
        r_sum      <= n_sum;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_out_ch   <= n_out_ch;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.red_out    = r_out_ch[0];
    assign o_res.green_out  = r_out_ch[1];
    assign o_res.blue_out   = r_out_ch[2];
    assign o_res.frame_last = r_out_last;
endmodule
